// ===== rtl/scbd_pkg.sv =====
// Shared types and constants for the serial card bus decoder.
// No dependencies; imported by scbd_core and serial_card_bus_decoder.
`default_nettype none

package scbd_pkg;

    typedef struct packed {
        logic [11:0] address;
        logic        is_read;
        logic [7:0]  write_data;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic        tx_ready;
    } t_in_item;

    typedef struct packed {
        logic        drives_bus;
        logic [7:0]  read_data;
        logic        rom_read;
        logic [10:0] rom_address;
        logic        rx_pop;
        logic        tx_push;
        logic [7:0]  tx_byte;
    } t_out_item;

    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DIP_ONE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_TWO = CFG_IDX_W'(1);

    localparam logic [7:0] DIP_ONE_RESET = 8'hEE;
    localparam logic [7:0] DIP_TWO_RESET = 8'h70;

    localparam logic [3:0] REG_DIP_ONE = 4'h1;
    localparam logic [3:0] REG_DIP_TWO = 4'h2;
    localparam logic [3:0] REG_DATA    = 4'h8;
    localparam logic [3:0] REG_STATUS  = 4'h9;
    localparam logic [3:0] REG_COMMAND = 4'hA;
    localparam logic [3:0] REG_CONTROL = 4'hB;

    localparam logic [11:0] ADDR_EXP_OFF   = 12'hFFF;
    localparam logic [10:0] SLOT_ROM_BASE  = 11'h700;
    localparam logic [7:0]  PRG_RESET_KEEP = 8'hE0;

    function automatic logic [7:0] word_mask(input logic [1:0] len_sel);
        logic [7:0] m;
        case (len_sel)
            2'd0:    m = 8'hFF;
            2'd1:    m = 8'h7F;
            2'd2:    m = 8'h3F;
            default: m = 8'h1F;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/serial_card_bus_decoder.sv =====
// Top level of the serial card bus decoder: input/output staging and switch registers.
// Depends on scbd_pkg and scbd_core.
`default_nettype none

// Each bus access transaction enters an input register, is decoded combinationally by
// scbd_core, and lands in an output register: one transaction per clock while
// o_in_stall is low. The output register frees while a result waits only when the
// downstream side takes it; o_in_stall rises only when both stages are full and
// i_out_stall is high. Switch-bank bytes are written through the configuration port
// (index 0 and 1, others ignored), which is always ready.

module serial_card_bus_decoder
    import scbd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    t_in_item   r_in;
    logic       r_in_valid;
    t_out_item  r_out;
    logic       r_out_valid;
    logic [7:0] r_dip_one;
    logic [7:0] r_dip_two;

    t_out_item  result;
    logic       out_free;
    logic       step;
    logic       in_take;

    assign out_free = !r_out_valid || !i_out_stall;
    assign step     = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take || step) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_one <= DIP_ONE_RESET;
            r_dip_two <= DIP_TWO_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DIP_ONE) begin
                r_dip_one <= i_cfg_data;
            end
            if (i_cfg_index == CFG_DIP_TWO) begin
                r_dip_two <= i_cfg_data;
            end
        end
    end

    scbd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_in),
        .i_dip_one (r_dip_one),
        .i_dip_two (r_dip_two),
        .o_result  (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/scbd_core.sv =====
// Bus access decode and ACIA register state (command, control, mask, expansion).
// Depends on scbd_pkg.
`default_nettype none

module scbd_core
    import scbd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_item  i_item,
    input  wire logic [7:0] i_dip_one,
    input  wire logic [7:0] i_dip_two,
    output t_out_item      o_result
);

    logic [7:0] r_command, n_command;
    logic [7:0] r_control, n_control;
    logic [7:0] r_mask, n_mask;
    logic       r_exp_active, n_exp_active;

    logic       devsel;
    logic       strobe;
    logic [3:0] reg_sel;

    assign devsel  = (i_item.address[11:8] == 4'h0);
    assign strobe  = i_item.address[11];
    assign reg_sel = i_item.address[3:0];

    always_comb begin
        o_result     = '0;
        n_command    = r_command;
        n_control    = r_control;
        n_mask       = r_mask;
        n_exp_active = r_exp_active;

        if (i_item.is_read) begin
            if (devsel) begin
                o_result.drives_bus = 1'b1;
                case (reg_sel)
                    REG_DIP_ONE: o_result.read_data = i_dip_one;
                    REG_DIP_TWO: o_result.read_data = i_dip_two;
                    REG_DATA: begin
                        o_result.read_data = i_item.rx_byte & r_mask;
                        o_result.rx_pop    = i_item.rx_valid;
                    end
                    REG_STATUS: begin
                        o_result.read_data = {3'b000, i_item.tx_ready, i_item.rx_valid, 3'b000};
                    end
                    REG_COMMAND: o_result.read_data = r_command;
                    REG_CONTROL: o_result.read_data = r_control;
                    default:     o_result.drives_bus = 1'b0;
                endcase
            end else if (!strobe) begin
                o_result.rom_read    = 1'b1;
                o_result.rom_address = SLOT_ROM_BASE | i_item.address[10:0];
            end else if (r_exp_active && (i_item.address != ADDR_EXP_OFF)) begin
                o_result.rom_read    = 1'b1;
                o_result.rom_address = i_item.address[10:0];
            end
        end else if (devsel) begin
            case (reg_sel)
                REG_DATA: begin
                    if (i_item.tx_ready) begin
                        o_result.tx_push = 1'b1;
                        o_result.tx_byte = i_item.write_data & r_mask;
                    end
                end
                REG_STATUS:  n_command = r_command & PRG_RESET_KEEP;
                REG_COMMAND: n_command = i_item.write_data;
                REG_CONTROL: begin
                    n_control = i_item.write_data;
                    n_mask    = word_mask(i_item.write_data[6:5]);
                end
                default: ;
            endcase
        end

        if (!devsel && !strobe) begin
            n_exp_active = 1'b1;
        end else if (i_item.address == ADDR_EXP_OFF) begin
            n_exp_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command    <= '0;
            r_control    <= '0;
            r_mask       <= 8'hFF;
            r_exp_active <= 1'b0;
        end else if (i_step) begin
            r_command    <= n_command;
            r_control    <= n_control;
            r_mask       <= n_mask;
            r_exp_active <= n_exp_active;
        end
    end

    a_exp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_item.address == ADDR_EXP_OFF) |=> !r_exp_active)
        else $error("expansion ROM still active after 0xFFF access");

    a_mask_follows_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_mask == word_mask(r_control[6:5])))
        else $error("character mask out of step with control register");

    a_one_bus_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(o_result.drives_bus && o_result.rom_read))
        else $error("register and ROM both selected");

    a_pop_is_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.rx_pop |-> (o_result.drives_bus && !o_result.tx_push))
        else $error("receive pop outside a data register read");

endmodule

`default_nettype wire

// ===== tb/serial_card_bus_decoder_tb.sv =====
`timescale 1ns / 100ps
// Testbench for serial_card_bus_decoder: directed and random bus access transactions,
// each predicted and checked by a scoreboard. Depends on scbd_pkg and the decoder RTL.

module serial_card_bus_decoder_tb;
    import scbd_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int PHASE_ITEMS  = 96;
    localparam int HOLD_ITEMS   = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = CFG_IDX_W'(7);
    localparam logic [3:0]           REG_UNUSED = 4'h5;
    localparam logic [3:0]           REG_NONE   = 4'h0;

    class decode_scoreboard;
        logic [7:0] switch_one;
        logic [7:0] switch_two;
        logic [7:0] command_reg;
        logic [7:0] control_reg;
        logic [7:0] char_mask;
        bit         exp_rom_on;
        logic [7:0] len_masks [4];
        t_out_item  pending_results[$];
        int         mismatches;
        int         accesses;
        int         results;
        int         rom_fetches;
        int         pushes;
        int         pops;

        function void clear_state();
            switch_one  = DIP_ONE_RESET;
            switch_two  = DIP_TWO_RESET;
            command_reg = 8'h00;
            control_reg = 8'h00;
            char_mask   = 8'hFF;
            exp_rom_on  = 1'b0;
            len_masks   = '{8'hFF, 8'h7F, 8'h3F, 8'h1F};
        endfunction

        function void write_switch(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
            if (idx == CFG_DIP_ONE) begin
                switch_one = value;
            end else if (idx == CFG_DIP_TWO) begin
                switch_two = value;
            end
        endfunction

        function void note_access(t_in_item acc);
            t_out_item  r;
            logic [3:0] nib;
            bit         devsel;
            bit         upper;
            r      = '0;
            nib    = acc.address[3:0];
            devsel = (acc.address[11:8] == 4'h0);
            upper  = acc.address[11];
            accesses++;
            if (acc.is_read) begin
                if (devsel) begin
                    r.drives_bus = 1'b1;
                    case (nib)
                        REG_DIP_ONE: r.read_data = switch_one;
                        REG_DIP_TWO: r.read_data = switch_two;
                        REG_DATA: begin
                            r.read_data = acc.rx_byte & char_mask;
                            r.rx_pop    = acc.rx_valid;
                        end
                        REG_STATUS:  r.read_data = {3'b000, acc.tx_ready, acc.rx_valid, 3'b000};
                        REG_COMMAND: r.read_data = command_reg;
                        REG_CONTROL: r.read_data = control_reg;
                        default:     r.drives_bus = 1'b0;
                    endcase
                end else if (!upper) begin
                    r.rom_read    = 1'b1;
                    r.rom_address = SLOT_ROM_BASE | {3'b000, acc.address[7:0]};
                end else if (exp_rom_on && acc.address != ADDR_EXP_OFF) begin
                    r.rom_read    = 1'b1;
                    r.rom_address = acc.address[10:0];
                end
            end else if (devsel) begin
                case (nib)
                    REG_DATA: begin
                        if (acc.tx_ready) begin
                            r.tx_push = 1'b1;
                            r.tx_byte = acc.write_data & char_mask;
                        end
                    end
                    REG_STATUS:  command_reg = command_reg & PRG_RESET_KEEP;
                    REG_COMMAND: command_reg = acc.write_data;
                    REG_CONTROL: begin
                        control_reg = acc.write_data;
                        char_mask   = len_masks[acc.write_data[6:5]];
                    end
                    default: ;
                endcase
            end
            // slot ROM window arms the expansion ROM, the off address disarms it
            if (!devsel && !upper) begin
                exp_rom_on = 1'b1;
            end else if (acc.address == ADDR_EXP_OFF) begin
                exp_rom_on = 1'b0;
            end
            pending_results.push_back(r);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding: %h", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results++;
            rom_fetches += want.rom_read;
            pushes      += want.tx_push;
            pops        += want.rx_pop;
            compare("drives_bus", 16'(want.drives_bus), 16'(got.drives_bus));
            compare("read_data", 16'(want.read_data), 16'(got.read_data));
            compare("rom_read", 16'(want.rom_read), 16'(got.rom_read));
            compare("rom_address", 16'(want.rom_address), 16'(got.rom_address));
            compare("rx_pop", 16'(want.rx_pop), 16'(got.rx_pop));
            compare("tx_push", 16'(want.tx_push), 16'(got.tx_push));
            compare("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    decode_scoreboard sb;
    bit               rx_hold_req = 1'b0;
    int unsigned      cycle_count = 0;
    int               settings_applied = 0;
    logic [3:0]       live_regs [6] = '{REG_DIP_ONE, REG_DIP_TWO, REG_DATA,
                                        REG_STATUS, REG_COMMAND, REG_CONTROL};

    serial_card_bus_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    // downstream stall pattern: segments of random duty, duty zero means no stalls
    initial begin : out_side
        int seg_len;
        int duty;
        i_out_stall <= 1'b0;
        forever begin
            seg_len = $urandom_range(10, 60);
            duty    = $urandom_range(0, 3);
            repeat (seg_len) begin
                @(posedge i_clk);
                if (rx_hold_req) begin
                    rx_hold_req = 1'b0;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                i_out_stall <= (duty != 0) && ($urandom_range(0, 3) < duty);
            end
        end
    end

    function automatic t_in_item make_access(logic [11:0] addr, logic rd, logic [7:0] wdata,
                                             logic [7:0] rxb, logic rxv, logic txr);
        t_in_item acc;
        acc.address    = addr;
        acc.is_read    = rd;
        acc.write_data = wdata;
        acc.rx_byte    = rxb;
        acc.rx_valid   = rxv;
        acc.tx_ready   = txr;
        return acc;
    endfunction

    function automatic t_in_item random_access();
        t_in_item   acc;
        int         pick;
        logic [3:0] nib;
        acc.is_read    = 1'($urandom);
        acc.write_data = 8'($urandom);
        acc.rx_byte    = 8'($urandom);
        acc.rx_valid   = 1'($urandom);
        acc.tx_ready   = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            nib = ($urandom_range(0, 4) == 0) ? 4'($urandom) : live_regs[$urandom_range(0, 5)];
            acc.address = {4'h0, 4'($urandom), nib};
        end else if (pick < 75) begin
            acc.address = 12'($urandom_range(12'h100, 12'h7FF));
        end else if (pick < 93) begin
            acc.address = 12'($urandom_range(12'h800, 12'hFFF));
        end else if (pick < 97) begin
            acc.address = ADDR_EXP_OFF;
        end else begin
            acc.address = 12'($urandom);
        end
        return acc;
    endfunction

    task automatic send_access(input t_in_item acc);
        i_in_valid <= 1'b1;
        i_in_data  <= acc;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_access(acc);
    endtask

    task automatic run_bursts(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) send_access(random_access());
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // output hold while the input keeps coming, so both stages fill and stall
    task automatic run_hold();
        rx_hold_req = 1'b1;
        repeat (HOLD_ITEMS) send_access(random_access());
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_switch(idx, value);
    endtask

    task automatic apply_switches(input logic [7:0] one, input logic [7:0] two,
                                  input bit poke_spare);
        cfg_write(CFG_DIP_ONE, one);
        cfg_write(CFG_DIP_TWO, two);
        if (poke_spare) begin
            cfg_write(CFG_SPARE, 8'h5C);
        end
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // switch banks at reset value, status bits, word-length masks
        send_access(make_access({8'h00, REG_DIP_ONE}, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access({8'h0F, REG_DIP_TWO}, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access({8'h00, REG_STATUS}, 1'b1, 8'h00, 8'h00, 1'b1, 1'b0));
        send_access(make_access({8'h00, REG_STATUS}, 1'b1, 8'h00, 8'h00, 1'b0, 1'b1));
        send_access(make_access({8'h00, REG_CONTROL}, 1'b0, 8'h20, 8'h00, 1'b0, 1'b0));
        send_access(make_access({8'h00, REG_DATA}, 1'b1, 8'h00, 8'hFF, 1'b1, 1'b0));
        // data read on an empty queue: no pop
        send_access(make_access({8'h00, REG_DATA}, 1'b1, 8'h00, 8'hFF, 1'b0, 1'b0));
        send_access(make_access({8'h00, REG_DATA}, 1'b0, 8'hFF, 8'h00, 1'b0, 1'b1));
        // data write on a full queue: dropped
        send_access(make_access({8'h00, REG_DATA}, 1'b0, 8'hFF, 8'h00, 1'b0, 1'b0));
        send_access(make_access({8'h00, REG_CONTROL}, 1'b0, 8'hE0, 8'h00, 1'b0, 1'b0));
        send_access(make_access({8'h00, REG_DATA}, 1'b0, 8'hFF, 8'h00, 1'b1, 1'b1));
        send_access(make_access({8'h00, REG_COMMAND}, 1'b0, 8'hFF, 8'h00, 1'b0, 1'b0));
        // programmed reset
        send_access(make_access({8'h00, REG_STATUS}, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access({8'h00, REG_COMMAND}, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access({8'h00, REG_CONTROL}, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        // unused device-select nibbles
        send_access(make_access({8'h00, REG_UNUSED}, 1'b1, 8'h00, 8'hFF, 1'b1, 1'b1));
        send_access(make_access({8'h00, REG_UNUSED}, 1'b0, 8'hFF, 8'hFF, 1'b1, 1'b1));
        // expansion ROM arming and disarming
        send_access(make_access(12'h3AB, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access(12'h9CD, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access(ADDR_EXP_OFF, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access(12'h800, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access(12'h7FF, 1'b0, 8'hFF, 8'h00, 1'b0, 1'b0));
        send_access(make_access(12'hFFE, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access(ADDR_EXP_OFF, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0));
        send_access(make_access({8'h00, REG_NONE}, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0));

        wait_drained();
        apply_switches(8'h00, 8'hFF, 1'b1);
        run_bursts(PHASE_ITEMS);
        run_hold();

        wait_drained();
        apply_switches(8'hFF, 8'h00, 1'b0);
        run_bursts(PHASE_ITEMS);

        wait_drained();
        apply_switches(8'($urandom), 8'($urandom), 1'b0);
        run_bursts(PHASE_ITEMS);
        run_hold();

        wait_drained();
        apply_switches(8'hA5, 8'h5A, 1'b0);
        run_bursts(PHASE_ITEMS);

        wait_drained();
        apply_switches(DIP_ONE_RESET, DIP_TWO_RESET, 1'b0);
        run_bursts(PHASE_ITEMS);

        wait_drained();
        $display("%0d bus transactions sent, %0d results checked across %0d switch settings",
                 sb.accesses, sb.results, settings_applied);
        $display("%0d ROM fetches, %0d transmit pushes, %0d receive pops, two long output holds",
                 sb.rom_fetches, sb.pushes, sb.pops);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scbd_pkg.sv
rtl/scbd_core.sv
rtl/serial_card_bus_decoder.sv
tb/serial_card_bus_decoder_tb.sv
